// ===== design/pci_local_bus_bridge_registers_macros.svh =====
// Assertion macros for the bridge register file.
// Used by pci_local_bus_bridge_registers.sv; depends on nothing.
`ifndef PCI_LOCAL_BUS_BRIDGE_REGISTERS_MACROS_SVH
`define PCI_LOCAL_BUS_BRIDGE_REGISTERS_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PLBR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plbr: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PLBR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plbr: next-cycle check failed");

`endif

// ===== design/plbr_pkg.sv =====
// Types and constants of the bridge register file.
// No dependencies; used by pci_local_bus_bridge_registers.sv.
package plbr_pkg;

    typedef struct packed {
        logic        func;
        logic [4:0]  reg_offset;
        logic [31:0] write_data;
        logic [3:0]  user_in;
    } t_request;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  user_out;
        logic        user_out_valid;
        logic        window_update;
        logic [1:0]  window_index;
        logic        window_enabled;
        logic [4:0]  window_size_log2;
        logic [1:0]  window_kind;
        logic        cfg_mem_enable;
        logic        cfg_io_enable;
        logic        space_select_changed;
    } t_response;

    // Access type
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Dword register map
    localparam logic [4:0] OFF_RANGE_FIRST = 5'd0;
    localparam logic [4:0] OFF_RANGE_LAST  = 5'd3;
    localparam logic [4:0] OFF_ROM_RANGE   = 5'd4;
    localparam logic [4:0] OFF_BASE_FIRST  = 5'd5;
    localparam logic [4:0] OFF_BASE_LAST   = 5'd8;
    localparam logic [4:0] OFF_ROM_BASE    = 5'd9;
    localparam logic [4:0] OFF_DESC_FIRST  = 5'd10;
    localparam logic [4:0] OFF_DESC_LAST   = 5'd13;
    localparam logic [4:0] OFF_ROM_DESC    = 5'd14;
    localparam logic [4:0] OFF_CS_FIRST    = 5'd15;
    localparam logic [4:0] OFF_CS_LAST     = 5'd18;
    localparam logic [4:0] OFF_INT_CSR     = 5'd19;
    localparam logic [4:0] OFF_CONTROL     = 5'd20;

    // Reset values
    localparam logic [31:0] RANGE0_RESET    = 32'h0ff0_0000;
    localparam logic [31:0] DESC_RESET      = 32'h0080_0000;
    localparam logic [31:0] ROM_RANGE_RESET = 32'h07ff_8000;
    localparam logic [31:0] ROM_BASE_RESET  = 32'h0008_0000;

    // Control register fields
    localparam logic [31:0] SPACE_SEL_MASK = 32'h0000_3000;
    localparam logic [1:0]  SEL_MEM_ONLY   = 2'd1;
    localparam logic [1:0]  SEL_IO_ONLY    = 2'd2;

    // Window kinds
    localparam logic [1:0] KIND_MEM      = 2'd0;
    localparam logic [1:0] KIND_PREFETCH = 2'd1;
    localparam logic [1:0] KIND_IO       = 2'd2;

    // Highest chip-select bit that can set the window size
    localparam int CS_SIZE_TOP = 27;

    // log2 of window size: lowest set bit b among 1..27 gives b+1, none gives 0
    function automatic logic [4:0] cs_size_log2(input logic [31:0] cs);
        logic [4:0] size;
        size = 5'd0;
        for (int b = CS_SIZE_TOP; b >= 1; b--) begin
            if (cs[b]) begin
                size = 5'(b + 1);
            end
        end
        return size;
    endfunction

endpackage

// ===== design/pci_local_bus_bridge_registers.sv =====
// Register file of a PCI-to-local-bus bridge: request decode, register
// storage, window decode and a two-entry response buffer. Uses plbr_pkg
// and pci_local_bus_bridge_registers_macros.svh.
//
// Usage
//   Request channel (i_req_valid / o_req_ready / i_req): one dword read or
//   write per request at a register offset, plus the user input pin levels.
//   Response channel (o_rsp_valid / i_rsp_ready / o_rsp): exactly one
//   response per request, in order.
//   The response is registered in the response register, or in the skid
//   entry while the output stalls. Throughput: one request per cycle while
//   o_req_ready is high. Update and decode are a single pass of muxes and
//   a 27-bit priority encoder between the request port and the buffer.
//   Reset (synchronous, active low) loads every register with its reset
//   value and empties the response buffer.
//   Stall: a response register plus one skid entry sit on the output; a
//   request is still taken while one response waits, and o_req_ready drops
//   only while both entries are full.
`include "pci_local_bus_bridge_registers_macros.svh"

module pci_local_bus_bridge_registers (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  plbr_pkg::t_request i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output plbr_pkg::t_response o_rsp
);

    // Architectural registers
    logic [31:0] r_range [4];
    logic [31:0] r_base  [4];
    logic [31:0] r_desc  [4];
    logic [31:0] r_cs    [4];
    logic [31:0] r_rom_range;
    logic [31:0] r_rom_base;
    logic [31:0] r_rom_desc;
    logic [31:0] r_int_csr;
    logic [31:0] r_control;

    logic [31:0] n_range [4];
    logic [31:0] n_base  [4];
    logic [31:0] n_desc  [4];
    logic [31:0] n_cs    [4];
    logic [31:0] n_rom_range;
    logic [31:0] n_rom_base;
    logic [31:0] n_rom_desc;
    logic [31:0] n_int_csr;
    logic [31:0] n_control;

    // Response buffer
    logic                r_rsp_valid;
    plbr_pkg::t_response r_rsp;
    logic                r_skid_valid;
    plbr_pkg::t_response r_skid;

    logic                req_fire;
    logic                rsp_fire;
    logic [1:0]          win_idx;
    logic                win_hit;
    logic                is_write;
    logic [4:0]          win_size;
    logic [31:0]         win_cs;
    logic [31:0]         win_range;
    logic [1:0]          space_sel;
    plbr_pkg::t_response new_rsp;

    assign o_req_ready = !r_skid_valid;
    assign req_fire    = i_req_valid && o_req_ready;
    assign rsp_fire    = r_rsp_valid && i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign is_write    = (i_req.func == plbr_pkg::FUNC_WRITE);

    // Which local window (0..3) the offset belongs to, if any
    always_comb begin
        win_idx = 2'd0;
        win_hit = 1'b0;
        case (i_req.reg_offset) inside
            [plbr_pkg::OFF_RANGE_FIRST:plbr_pkg::OFF_RANGE_LAST]: begin
                win_idx = 2'(i_req.reg_offset - plbr_pkg::OFF_RANGE_FIRST);
                win_hit = 1'b1;
            end
            [plbr_pkg::OFF_BASE_FIRST:plbr_pkg::OFF_BASE_LAST]: begin
                win_idx = 2'(i_req.reg_offset - plbr_pkg::OFF_BASE_FIRST);
                win_hit = 1'b1;
            end
            [plbr_pkg::OFF_DESC_FIRST:plbr_pkg::OFF_DESC_LAST]: begin
                win_idx = 2'(i_req.reg_offset - plbr_pkg::OFF_DESC_FIRST);
                win_hit = 1'b1;
            end
            [plbr_pkg::OFF_CS_FIRST:plbr_pkg::OFF_CS_LAST]: begin
                win_idx = 2'(i_req.reg_offset - plbr_pkg::OFF_CS_FIRST);
                win_hit = 1'b1;
            end
            default: begin
                win_idx = 2'd0;
                win_hit = 1'b0;
            end
        endcase
    end

    // Register update and read mux
    always_comb begin
        n_range     = r_range;
        n_base      = r_base;
        n_desc      = r_desc;
        n_cs        = r_cs;
        n_rom_range = r_rom_range;
        n_rom_base  = r_rom_base;
        n_rom_desc  = r_rom_desc;
        n_int_csr   = r_int_csr;
        n_control   = r_control;
        new_rsp     = '0;

        if (is_write) begin
            case (i_req.reg_offset) inside
                [plbr_pkg::OFF_RANGE_FIRST:plbr_pkg::OFF_RANGE_LAST]:
                    n_range[win_idx] = i_req.write_data;
                plbr_pkg::OFF_ROM_RANGE: n_rom_range = i_req.write_data;
                [plbr_pkg::OFF_BASE_FIRST:plbr_pkg::OFF_BASE_LAST]:
                    n_base[win_idx] = i_req.write_data;
                plbr_pkg::OFF_ROM_BASE:  n_rom_base = i_req.write_data;
                [plbr_pkg::OFF_DESC_FIRST:plbr_pkg::OFF_DESC_LAST]:
                    n_desc[win_idx] = i_req.write_data;
                plbr_pkg::OFF_ROM_DESC:  n_rom_desc = i_req.write_data;
                [plbr_pkg::OFF_CS_FIRST:plbr_pkg::OFF_CS_LAST]:
                    n_cs[win_idx] = i_req.write_data;
                plbr_pkg::OFF_INT_CSR:   n_int_csr = i_req.write_data;
                plbr_pkg::OFF_CONTROL: begin
                    n_control = i_req.write_data;
                    new_rsp.user_out_valid = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        new_rsp.user_out[i] = i_req.write_data[2 + i * 3];
                    end
                    new_rsp.space_select_changed =
                        |((r_control ^ i_req.write_data) & plbr_pkg::SPACE_SEL_MASK);
                end
                default: begin
                    // unmapped offsets ignore writes
                end
            endcase
        end else begin
            case (i_req.reg_offset) inside
                [plbr_pkg::OFF_RANGE_FIRST:plbr_pkg::OFF_RANGE_LAST]:
                    new_rsp.read_data = r_range[win_idx];
                plbr_pkg::OFF_ROM_RANGE: new_rsp.read_data = r_rom_range;
                [plbr_pkg::OFF_BASE_FIRST:plbr_pkg::OFF_BASE_LAST]:
                    new_rsp.read_data = r_base[win_idx];
                plbr_pkg::OFF_ROM_BASE:  new_rsp.read_data = r_rom_base;
                [plbr_pkg::OFF_DESC_FIRST:plbr_pkg::OFF_DESC_LAST]:
                    new_rsp.read_data = r_desc[win_idx];
                plbr_pkg::OFF_ROM_DESC:  new_rsp.read_data = r_rom_desc;
                [plbr_pkg::OFF_CS_FIRST:plbr_pkg::OFF_CS_LAST]:
                    new_rsp.read_data = r_cs[win_idx];
                plbr_pkg::OFF_INT_CSR:   new_rsp.read_data = r_int_csr;
                plbr_pkg::OFF_CONTROL: begin
                    // user bits configured as inputs latch the pin levels
                    for (int i = 0; i < 4; i++) begin
                        if (!r_control[1 + i * 3]) begin
                            n_control[2 + i * 3] = i_req.user_in[i];
                        end
                    end
                    new_rsp.read_data = n_control;
                end
                default: new_rsp.read_data = '0;
            endcase
        end

        // Window decode on the post-write register values
        if (is_write && win_hit) begin
            new_rsp.window_update = 1'b1;
            new_rsp.window_index  = win_idx;
            if (win_cs[0] && (win_size != 5'd0)) begin
                new_rsp.window_enabled   = 1'b1;
                new_rsp.window_size_log2 = win_size;
                if (win_range[0]) begin
                    new_rsp.window_kind = plbr_pkg::KIND_IO;
                end else if (win_range[3]) begin
                    new_rsp.window_kind = plbr_pkg::KIND_PREFETCH;
                end else begin
                    new_rsp.window_kind = plbr_pkg::KIND_MEM;
                end
            end
        end

        new_rsp.cfg_mem_enable = (space_sel != plbr_pkg::SEL_IO_ONLY);
        new_rsp.cfg_io_enable  = (space_sel != plbr_pkg::SEL_MEM_ONLY);
    end

    // Chip select and range of the addressed window, written value forwarded
    always_comb begin
        win_cs    = r_cs[win_idx];
        win_range = r_range[win_idx];
        if (is_write && (i_req.reg_offset inside
                {[plbr_pkg::OFF_CS_FIRST:plbr_pkg::OFF_CS_LAST]})) begin
            win_cs = i_req.write_data;
        end
        if (is_write && (i_req.reg_offset inside
                {[plbr_pkg::OFF_RANGE_FIRST:plbr_pkg::OFF_RANGE_LAST]})) begin
            win_range = i_req.write_data;
        end
    end

    assign win_size  = plbr_pkg::cs_size_log2(win_cs);
    assign space_sel = n_control[13:12];

    // Registers and response buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_range[i] <= (i == 0) ? plbr_pkg::RANGE0_RESET : '0;
            end
            r_base       <= '{default: '0};
            r_desc       <= '{default: plbr_pkg::DESC_RESET};
            r_cs         <= '{default: '0};
            r_rom_range  <= plbr_pkg::ROM_RANGE_RESET;
            r_rom_base   <= plbr_pkg::ROM_BASE_RESET;
            r_rom_desc   <= plbr_pkg::DESC_RESET;
            r_int_csr    <= '0;
            r_control    <= '0;
            r_rsp_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (req_fire) begin
                r_range     <= n_range;
                r_base      <= n_base;
                r_desc      <= n_desc;
                r_cs        <= n_cs;
                r_rom_range <= n_rom_range;
                r_rom_base  <= n_rom_base;
                r_rom_desc  <= n_rom_desc;
                r_int_csr   <= n_int_csr;
                r_control   <= n_control;
            end
            if (rsp_fire || !r_rsp_valid) begin
                if (r_skid_valid) begin
                    r_rsp        <= r_skid;
                    r_rsp_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_rsp       <= new_rsp;
                    r_rsp_valid <= req_fire;
                end
            end else if (req_fire) begin
                r_skid       <= new_rsp;
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Checks
    `PLBR_ASSERT_IMPL(a_skid_behind_rsp, i_clk, i_rst_n, r_skid_valid, r_rsp_valid)
    `PLBR_ASSERT_IMPL(a_cfg_space_visible, i_clk, i_rst_n, r_rsp_valid, (r_rsp.cfg_mem_enable || r_rsp.cfg_io_enable))
    `PLBR_ASSERT_IMPL(a_window_write_only, i_clk, i_rst_n, (r_rsp_valid && r_rsp.window_update), ((r_rsp.read_data == '0) && !r_rsp.user_out_valid))
    `PLBR_ASSERT_IMPL(a_disabled_window_clear, i_clk, i_rst_n, (r_rsp_valid && !r_rsp.window_enabled), ((r_rsp.window_size_log2 == '0) && (r_rsp.window_kind == plbr_pkg::KIND_MEM)))
    `PLBR_ASSERT_NEXT(a_control_written, i_clk, i_rst_n, (req_fire && is_write && (i_req.reg_offset == plbr_pkg::OFF_CONTROL)), (r_control == $past(i_req.write_data)))

endmodule

// ===== tb/plbr_access_checker.sv =====
// Request/response checker for the bridge register file: keeps a shadow copy
// of the registers, predicts each response and compares it. Depends on plbr_pkg.
module plbr_access_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  plbr_pkg::t_request  i_req,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  plbr_pkg::t_response i_rsp,
    output int                  o_error_count,
    output int                  o_pending_count
);

    // shadow register file
    logic [31:0] range_q [4];
    logic [31:0] base_q [4];
    logic [31:0] desc_q [4];
    logic [31:0] cs_q [4];
    logic [31:0] rom_range_q;
    logic [31:0] rom_base_q;
    logic [31:0] rom_desc_q;
    logic [31:0] int_csr_q;
    logic [31:0] control_q;

    plbr_pkg::t_response predicted_rsp_q [$];

    function automatic void load_reset_values();
        for (int w = 0; w < 4; w++) begin
            range_q[w] = (w == 0) ? plbr_pkg::RANGE0_RESET : '0;
            base_q[w]  = '0;
            desc_q[w]  = plbr_pkg::DESC_RESET;
            cs_q[w]    = '0;
        end
        rom_range_q = plbr_pkg::ROM_RANGE_RESET;
        rom_base_q  = plbr_pkg::ROM_BASE_RESET;
        rom_desc_q  = plbr_pkg::DESC_RESET;
        int_csr_q   = '0;
        control_q   = '0;
    endfunction

    // window fields only; lowest chip-select bit in 1..CS_SIZE_TOP sets the size
    function automatic plbr_pkg::t_response window_decode(input logic [1:0] win);
        plbr_pkg::t_response rsp;
        logic [31:0]         cs;
        logic [31:0]         rr;
        logic                found;
        logic [4:0]          size;
        rsp   = '0;
        cs    = cs_q[win];
        rr    = range_q[win];
        found = 1'b0;
        size  = '0;
        for (int b = 1; b <= plbr_pkg::CS_SIZE_TOP; b++) begin
            if (!found && cs[b]) begin
                found = 1'b1;
                size  = 5'(b + 1);
            end
        end
        rsp.window_update = 1'b1;
        rsp.window_index  = win;
        if (cs[0] && found) begin
            rsp.window_enabled   = 1'b1;
            rsp.window_size_log2 = size;
            rsp.window_kind      = rr[0] ? plbr_pkg::KIND_IO :
                                   (rr[3] ? plbr_pkg::KIND_PREFETCH : plbr_pkg::KIND_MEM);
        end
        return rsp;
    endfunction

    // updates the shadow registers for one request and returns its response
    function automatic plbr_pkg::t_response apply_access(input plbr_pkg::t_request req);
        plbr_pkg::t_response rsp;
        logic [4:0]          off;
        logic [4:0]          idx;
        logic [31:0]         old_ctl;
        logic [1:0]          sel;
        rsp = '0;
        off = req.reg_offset;
        idx = '0;
        if (req.func == plbr_pkg::FUNC_WRITE) begin
            if (off <= plbr_pkg::OFF_RANGE_LAST) begin
                idx = off - plbr_pkg::OFF_RANGE_FIRST;
                range_q[idx[1:0]] = req.write_data;
                rsp = window_decode(idx[1:0]);
            end else if (off == plbr_pkg::OFF_ROM_RANGE) begin
                rom_range_q = req.write_data;
            end else if (off <= plbr_pkg::OFF_BASE_LAST) begin
                idx = off - plbr_pkg::OFF_BASE_FIRST;
                base_q[idx[1:0]] = req.write_data;
                rsp = window_decode(idx[1:0]);
            end else if (off == plbr_pkg::OFF_ROM_BASE) begin
                rom_base_q = req.write_data;
            end else if (off <= plbr_pkg::OFF_DESC_LAST) begin
                idx = off - plbr_pkg::OFF_DESC_FIRST;
                desc_q[idx[1:0]] = req.write_data;
                rsp = window_decode(idx[1:0]);
            end else if (off == plbr_pkg::OFF_ROM_DESC) begin
                rom_desc_q = req.write_data;
            end else if (off <= plbr_pkg::OFF_CS_LAST) begin
                idx = off - plbr_pkg::OFF_CS_FIRST;
                cs_q[idx[1:0]] = req.write_data;
                rsp = window_decode(idx[1:0]);
            end else if (off == plbr_pkg::OFF_INT_CSR) begin
                int_csr_q = req.write_data;
            end else if (off == plbr_pkg::OFF_CONTROL) begin
                old_ctl   = control_q;
                control_q = req.write_data;
                for (int i = 0; i < 4; i++) begin
                    rsp.user_out[i] = control_q[2 + 3 * i];
                end
                rsp.user_out_valid       = 1'b1;
                rsp.space_select_changed =
                    |((old_ctl ^ control_q) & plbr_pkg::SPACE_SEL_MASK);
            end
        end else begin
            if (off <= plbr_pkg::OFF_RANGE_LAST) begin
                idx = off - plbr_pkg::OFF_RANGE_FIRST;
                rsp.read_data = range_q[idx[1:0]];
            end else if (off == plbr_pkg::OFF_ROM_RANGE) begin
                rsp.read_data = rom_range_q;
            end else if (off <= plbr_pkg::OFF_BASE_LAST) begin
                idx = off - plbr_pkg::OFF_BASE_FIRST;
                rsp.read_data = base_q[idx[1:0]];
            end else if (off == plbr_pkg::OFF_ROM_BASE) begin
                rsp.read_data = rom_base_q;
            end else if (off <= plbr_pkg::OFF_DESC_LAST) begin
                idx = off - plbr_pkg::OFF_DESC_FIRST;
                rsp.read_data = desc_q[idx[1:0]];
            end else if (off == plbr_pkg::OFF_ROM_DESC) begin
                rsp.read_data = rom_desc_q;
            end else if (off <= plbr_pkg::OFF_CS_LAST) begin
                idx = off - plbr_pkg::OFF_CS_FIRST;
                rsp.read_data = cs_q[idx[1:0]];
            end else if (off == plbr_pkg::OFF_INT_CSR) begin
                rsp.read_data = int_csr_q;
            end else if (off == plbr_pkg::OFF_CONTROL) begin
                // pins set up as inputs are latched into the register on read
                for (int i = 0; i < 4; i++) begin
                    if (!control_q[1 + 3 * i]) begin
                        control_q[2 + 3 * i] = req.user_in[i];
                    end
                end
                rsp.read_data = control_q;
            end
        end
        sel = control_q[13:12];
        rsp.cfg_mem_enable = (sel != plbr_pkg::SEL_IO_ONLY);
        rsp.cfg_io_enable  = (sel != plbr_pkg::SEL_MEM_ONLY);
        return rsp;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            o_error_count++;
        end
    endtask

    task automatic compare_response(input plbr_pkg::t_response want,
                                    input plbr_pkg::t_response got);
        check_field("read_data", want.read_data, got.read_data);
        check_field("user_out", 32'(want.user_out), 32'(got.user_out));
        check_field("user_out_valid", 32'(want.user_out_valid), 32'(got.user_out_valid));
        check_field("window_update", 32'(want.window_update), 32'(got.window_update));
        check_field("window_index", 32'(want.window_index), 32'(got.window_index));
        check_field("window_enabled", 32'(want.window_enabled), 32'(got.window_enabled));
        check_field("window_size_log2", 32'(want.window_size_log2),
                    32'(got.window_size_log2));
        check_field("window_kind", 32'(want.window_kind), 32'(got.window_kind));
        check_field("cfg_mem_enable", 32'(want.cfg_mem_enable), 32'(got.cfg_mem_enable));
        check_field("cfg_io_enable", 32'(want.cfg_io_enable), 32'(got.cfg_io_enable));
        check_field("space_select_changed", 32'(want.space_select_changed),
                    32'(got.space_select_changed));
    endtask

    // responses are matched before requests: one taken on this edge cannot
    // have its response on the same edge
    always @(posedge i_clk) begin : monitor
        plbr_pkg::t_response want;
        if (!i_rst_n) begin
            load_reset_values();
            predicted_rsp_q.delete();
            o_error_count = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (predicted_rsp_q.size() == 0) begin
                    $display("%0t: response with no request outstanding, actual %h",
                             $time, i_rsp);
                    o_error_count++;
                end else begin
                    want = predicted_rsp_q.pop_front();
                    compare_response(want, i_rsp);
                end
            end
            if (i_req_valid && i_req_ready) begin
                predicted_rsp_q.push_back(apply_access(i_req));
            end
        end
        o_pending_count = predicted_rsp_q.size();
    end

endmodule

// ===== tb/pci_local_bus_bridge_registers_tb.sv =====
// Top of the bridge register file testbench: clock, reset, request stimulus
// and response backpressure. Depends on plbr_pkg, plbr_access_checker and the DUT.
module pci_local_bus_bridge_registers_tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 725;
    localparam int QUIET_ITEMS    = 100;     // tail of the run with no idling
    localparam int TRAIL_CYCLES   = 10;      // idle time after the final drain
    localparam int TIMEOUT_CYCLES = 200000;

    // top of the dword map; offsets above OFF_CONTROL decode to nothing
    localparam logic [4:0] OFF_UNMAPPED_LAST = 5'd31;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_req_valid;
    logic                o_req_ready;
    plbr_pkg::t_request  i_req;
    logic                o_rsp_valid;
    logic                i_rsp_ready;
    plbr_pkg::t_response o_rsp;

    logic      quiet_tail = 1'b0;
    int        error_count;
    int        pending_count;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    pci_local_bus_bridge_registers u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    plbr_access_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .i_req_ready     (o_req_ready),
        .i_req           (i_req),
        .i_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .i_rsp           (o_rsp),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    function automatic plbr_pkg::t_request make_req(input logic fn, input logic [4:0] off,
                                                    input logic [31:0] data,
                                                    input logic [3:0] uin);
        plbr_pkg::t_request r;
        r.func       = fn;
        r.reg_offset = off;
        r.write_data = data;
        r.user_in    = uin;
        return r;
    endfunction

    // Write data that actually exercises the window decode: plain random data
    // usually has a low chip-select size bit set, so two times in five a single
    // lowest set bit is placed at a random position, usually with enable set.
    function automatic logic [31:0] random_write_data();
        int unsigned b;
        logic [31:0] d;
        case ($urandom_range(0, 4))
            0: d = '0;
            1: d = '1;
            2, 3: begin
                b = $urandom_range(1, 31);
                d = ($urandom() << b) | (32'd1 << b) | 32'($urandom_range(0, 3) != 0);
            end
            default: d = $urandom();
        endcase
        return d;
    endfunction

    // Entered at a falling edge, returns at the falling edge after the
    // request was taken. Valid stays high on return so back-to-back requests
    // never see a low/high pair in one step.
    task automatic issue(input plbr_pkg::t_request r);
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic hold_off(input int unsigned cycles);
        i_req_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // sender goes quiet until the checker has seen every response
    task automatic wait_for_responses();
        i_req_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Response side: random stalls, none in the quiet tail.
    initial begin : rsp_backpressure
        int unsigned stall;
        i_rsp_ready = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 6);
                i_rsp_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                i_rsp_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic       fn;
        logic [4:0] off;

        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // reset values, control read with all pins as inputs, unmapped read
        issue(make_req(plbr_pkg::FUNC_READ, plbr_pkg::OFF_RANGE_FIRST, '0, 4'h0));
        issue(make_req(plbr_pkg::FUNC_READ, plbr_pkg::OFF_ROM_RANGE, '1, 4'h0));
        issue(make_req(plbr_pkg::FUNC_READ, plbr_pkg::OFF_ROM_DESC, '0, 4'h0));
        issue(make_req(plbr_pkg::FUNC_READ, plbr_pkg::OFF_CONTROL, '0, 4'hf));
        issue(make_req(plbr_pkg::FUNC_READ, OFF_UNMAPPED_LAST, '1, 4'hf));
        // chip selects: enable without a size bit, smallest size, largest
        // size, and size bits only above the decoded range
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CS_FIRST,
                       32'h0000_0001, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CS_FIRST + 5'd1,
                       32'hffff_ffff, 4'h5));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CS_FIRST + 5'd2,
                       32'h0800_0001, 4'ha));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CS_LAST,
                       32'hf000_0001, 4'h0));
        // window kinds: I/O, prefetchable, plain memory, I/O over prefetch
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_RANGE_FIRST + 5'd1,
                       32'h0000_0001, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_RANGE_FIRST + 5'd2,
                       32'h0000_0008, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CS_FIRST,
                       32'h0000_0101, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_RANGE_LAST,
                       32'h0000_0009, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CS_LAST,
                       32'hffff_fff9, 4'h0));
        // base and descriptor writes re-decode too
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_BASE_FIRST + 5'd1,
                       32'hffff_ffff, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_DESC_LAST,
                       32'h0000_0000, 4'h0));
        // control: memory only with all pins as outputs, then I/O only, both with
        // select 3, both with select 0, and a write that leaves the space select unchanged
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CONTROL, 32'h0000_1fff, 4'h0));
        issue(make_req(plbr_pkg::FUNC_READ, plbr_pkg::OFF_CONTROL, '0, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CONTROL, 32'h0000_2000, 4'hf));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CONTROL, 32'hffff_ffff, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CONTROL, 32'hffff_cfff, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_CONTROL, 32'h0000_0000, 4'h0));
        issue(make_req(plbr_pkg::FUNC_READ, plbr_pkg::OFF_CONTROL, '0, 4'ha));
        // ignored write, interrupt CSR
        issue(make_req(plbr_pkg::FUNC_WRITE, OFF_UNMAPPED_LAST, 32'hffff_ffff, 4'h0));
        issue(make_req(plbr_pkg::FUNC_WRITE, plbr_pkg::OFF_INT_CSR, 32'hffff_ffff, 4'h0));

        wait_for_responses();

        // --- random part ---
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_responses();
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet_tail <= 1'b1;
            end
            fn = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0) begin
                off = 5'($urandom_range(plbr_pkg::OFF_CONTROL + 1, OFF_UNMAPPED_LAST));
            end else begin
                off = 5'($urandom_range(0, plbr_pkg::OFF_CONTROL));
            end
            issue(make_req(fn, off, random_write_data(), 4'($urandom_range(0, 15))));
            if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                hold_off($urandom_range(1, 6));
            end
        end

        // drain, then idle so that anything spurious can show
        wait_for_responses();
        repeat (TRAIL_CYCLES) @(negedge i_clk);

        if (error_count == 0 && pending_count == 0) begin
            $display("pci_local_bus_bridge_registers_tb passed");
        end else begin
            $display("pci_local_bus_bridge_registers_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("pci_local_bus_bridge_registers_tb failed");
        $finish;
    end

endmodule

// ===== pci_local_bus_bridge_registers.f =====
+incdir+design
design/plbr_pkg.sv
design/pci_local_bus_bridge_registers.sv
tb/plbr_access_checker.sv
tb/pci_local_bus_bridge_registers_tb.sv
